// ===== hw/rtl/bpf_pkg.sv =====
// ----------------------------------------------------------------------------
// bpf_pkg: shared types and constants of the Bezier path flattener
// Request/result payloads, queue entry layout, segment codes and the
// fixed-point sizes used by the forward-difference evaluator.
// ----------------------------------------------------------------------------
package bpf_pkg;

    // Segments per curve; must be a power of two.
    localparam int SEGMENTS = 32;
    localparam int SEG_LOG  = $clog2(SEGMENTS);
    localparam int CNT_W    = $clog2(SEGMENTS + 1);

    // Exact numerator accumulators (values stay well below 2^50).
    localparam int ACC_W    = 64;
    localparam int CUBE_SEG = SEGMENTS * SEGMENTS * SEGMENTS;
    localparam logic [ACC_W-1:0] RND_BIAS = ACC_W'(CUBE_SEG / 2);

    // Scaled point differences built by the front end.
    localparam int E1_W = 35;
    localparam int E2_W = 36;
    localparam int E3_W = 36;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request segment kinds.
    localparam logic [2:0] REQ_CLOSE = 3'd0;
    localparam logic [2:0] REQ_MOVE  = 3'd1;
    localparam logic [2:0] REQ_LINE  = 3'd2;
    localparam logic [2:0] REQ_QUAD  = 3'd3;
    localparam logic [2:0] REQ_CUBIC = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_CLOSE = 2'd0;
    localparam logic [1:0] KIND_MOVE  = 2'd1;
    localparam logic [1:0] KIND_LINE  = 2'd2;

    typedef enum logic [1:0] {
        CMD_CLOSE = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_LINE  = 2'd2,
        CMD_CURVE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] ctl1_x;
        logic [31:0] ctl1_y;
        logic [31:0] ctl2_x;
        logic [31:0] ctl2_y;
        logic [31:0] ctl3_x;
        logic [31:0] ctl3_y;
    } seg_req_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic        last_of_run;
    } pt_res_t;

    // Per-axis data: start point plus scaled differences (two's complement).
    typedef struct packed {
        logic [31:0]     p0;
        logic [E1_W-1:0] e1;
        logic [E2_W-1:0] e2;
        logic [E3_W-1:0] e3;
    } axis_coef_t;

    typedef struct packed {
        cmd_t       cmd;
        axis_coef_t ax;
        axis_coef_t ay;
    } q_entry_t;

endpackage

// ===== hw/rtl/bpf_front.sv =====
// ----------------------------------------------------------------------------
// bpf_front: request intake and classification
// Tracks the pen position, decodes the segment kind and prepares scaled
// control-point differences for the back end.
// ----------------------------------------------------------------------------
module bpf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  bpf_pkg::seg_req_t  req_data,
    input  logic               q_full,
    output logic               push,
    output bpf_pkg::q_entry_t  push_data
);
    import bpf_pkg::*;

    logic [31:0] ref_x_reg, ref_x_next;
    logic [31:0] ref_y_reg, ref_y_next;
    logic        accept;
    logic        known;

    // Quadratic: e1 = 2(p1-p0), e2 = p0-2p1+p2, e3 = 0
    // Cubic:     e1 = 3(p1-p0), e2 = 3(p0-2p1+p2), e3 = p3-3p2+3p1-p0
    function automatic axis_coef_t prep_axis(input logic [31:0] a0, input logic [31:0] a1,
                                             input logic [31:0] a2, input logic [31:0] a3,
                                             input logic cubic);
        logic signed [E1_W-1:0] d1;
        logic signed [E2_W-1:0] d2;
        logic signed [E3_W-1:0] dd;
        logic signed [E3_W-1:0] d3;
        axis_coef_t             c;
        d1 = E1_W'($signed(a1)) - E1_W'($signed(a0));
        d2 = E2_W'($signed(a0)) - (E2_W'($signed(a1)) <<< 1) + E2_W'($signed(a2));
        dd = E3_W'($signed(a1)) - E3_W'($signed(a2));
        d3 = E3_W'($signed(a3)) - E3_W'($signed(a0)) + (dd <<< 1) + dd;
        c.p0 = a0;
        if (cubic)
        begin
            c.e1 = (d1 <<< 1) + d1;
            c.e2 = (d2 <<< 1) + d2;
            c.e3 = d3;
        end
        else
        begin
            c.e1 = d1 <<< 1;
            c.e2 = d2;
            c.e3 = '0;
        end
        return c;
    endfunction

    assign req_ready = !q_full;
    assign accept    = req_valid && req_ready;
    assign push      = accept && known;

    always_comb
    begin
        known      = 1'b1;
        ref_x_next = ref_x_reg;
        ref_y_next = ref_y_reg;
        push_data  = '0;
        unique case (req_data.req_type)
            REQ_CLOSE:
            begin
                push_data.cmd = CMD_CLOSE;
                ref_x_next    = '0;
                ref_y_next    = '0;
            end
            REQ_MOVE, REQ_LINE:
            begin
                push_data.cmd   = (req_data.req_type == REQ_MOVE) ? CMD_MOVE : CMD_LINE;
                push_data.ax.p0 = req_data.ctl1_x;
                push_data.ay.p0 = req_data.ctl1_y;
                ref_x_next      = req_data.ctl1_x;
                ref_y_next      = req_data.ctl1_y;
            end
            REQ_QUAD:
            begin
                push_data.cmd = CMD_CURVE;
                push_data.ax  = prep_axis(ref_x_reg, req_data.ctl1_x, req_data.ctl2_x,
                                          req_data.ctl2_x, 1'b0);
                push_data.ay  = prep_axis(ref_y_reg, req_data.ctl1_y, req_data.ctl2_y,
                                          req_data.ctl2_y, 1'b0);
                ref_x_next    = req_data.ctl2_x;
                ref_y_next    = req_data.ctl2_y;
            end
            REQ_CUBIC:
            begin
                push_data.cmd = CMD_CURVE;
                push_data.ax  = prep_axis(ref_x_reg, req_data.ctl1_x, req_data.ctl2_x,
                                          req_data.ctl3_x, 1'b1);
                push_data.ay  = prep_axis(ref_y_reg, req_data.ctl1_y, req_data.ctl2_y,
                                          req_data.ctl3_y, 1'b1);
                ref_x_next    = req_data.ctl3_x;
                ref_y_next    = req_data.ctl3_y;
            end
            default:
                known = 1'b0;  // undefined kinds are dropped
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x_reg <= '0;
            ref_y_reg <= '0;
        end
        else if (push)
        begin
            ref_x_reg <= ref_x_next;
            ref_y_reg <= ref_y_next;
        end
    end

endmodule

// ===== hw/rtl/bpf_queue.sv =====
// ----------------------------------------------------------------------------
// bpf_queue: short FIFO between front and back end
// Register-based entries, one write and one read port.
// ----------------------------------------------------------------------------
module bpf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bpf_pkg::q_entry_t  push_data,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output bpf_pkg::q_entry_t  head
);
    import bpf_pkg::*;

    q_entry_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            return '0;
        else
            return p + QPTR_W'(1);
    endfunction

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== hw/rtl/bpf_back.sv =====
// ----------------------------------------------------------------------------
// bpf_back: segment execution and point generation
// Passes close/move/line through and walks curves by exact third-order
// forward differencing, one rounded point per cycle unless the result is stalled.
// ----------------------------------------------------------------------------
module bpf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  bpf_pkg::q_entry_t  head,
    output logic               pop,
    output logic               res_valid,
    input  logic               res_ready,
    output bpf_pkg::pt_res_t   res_data
);
    import bpf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_RUN  = 3'b100
    } state_t;

    // Numerator N^3 * B(i) and its forward differences for one axis.
    typedef struct packed {
        logic [ACC_W-1:0] f;
        logic [ACC_W-1:0] d1;
        logic [ACC_W-1:0] d2;
        logic [ACC_W-1:0] d3;
    } acc_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    acc_t             acc_x_reg, acc_x_next;
    acc_t             acc_y_reg, acc_y_next;
    logic             res_valid_reg, res_valid_next;
    pt_res_t          res_reg, res_next;
    logic             can_load;
    logic             last_pt;

    // num(i) = a + b i + c i^2 + d i^3 with a = p0 N^3, b = e1 N^2, c = e2 N, d = e3
    function automatic acc_t setup_axis(input axis_coef_t c);
        logic signed [ACC_W-1:0] b;
        logic signed [ACC_W-1:0] cc;
        logic signed [ACC_W-1:0] d;
        logic signed [ACC_W-1:0] d6;
        acc_t                    r;
        b    = ACC_W'($signed(c.e1)) <<< (2 * SEG_LOG);
        cc   = ACC_W'($signed(c.e2)) <<< SEG_LOG;
        d    = ACC_W'($signed(c.e3));
        d6   = (d <<< 2) + (d <<< 1);
        r.f  = ACC_W'($signed(c.p0)) <<< (3 * SEG_LOG);
        r.d1 = b + cc + d;
        r.d2 = (cc <<< 1) + d6;
        r.d3 = d6;
        return r;
    endfunction

    function automatic acc_t step_axis(input acc_t a);
        acc_t r;
        r.f  = a.f + a.d1;
        r.d1 = a.d1 + a.d2;
        r.d2 = a.d2 + a.d3;
        r.d3 = a.d3;
        return r;
    endfunction

    // floor(num / N^3 + 1/2); the sample is a convex combination, so 32 bits hold it
    function automatic logic [31:0] round_pt(input logic [ACC_W-1:0] f);
        logic signed [ACC_W-1:0] s;
        s = $signed(f + RND_BIAS) >>> (3 * SEG_LOG);
        return s[31:0];
    endfunction

    assign can_load  = !res_valid_reg || res_ready;
    assign last_pt   = (cnt_reg == CNT_W'(SEGMENTS));
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        pop            = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    if (head.cmd == CMD_CURVE)
                        state_next = ST_LOAD;
                    else if (can_load)
                    begin
                        res_valid_next       = 1'b1;
                        res_next.last_of_run = 1'b1;
                        res_next.out_x       = head.ax.p0;
                        res_next.out_y       = head.ay.p0;
                        unique case (head.cmd)
                            CMD_MOVE: res_next.out_kind = KIND_MOVE;
                            CMD_LINE: res_next.out_kind = KIND_LINE;
                            default:
                            begin
                                res_next.out_kind = KIND_CLOSE;
                                res_next.out_x    = '0;
                                res_next.out_y    = '0;
                            end
                        endcase
                        pop = 1'b1;
                    end
                end
            end
            ST_LOAD:
            begin
                acc_x_next = setup_axis(head.ax);
                acc_y_next = setup_axis(head.ay);
                cnt_next   = '0;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (can_load)
                begin
                    res_valid_next       = 1'b1;
                    res_next.out_kind    = KIND_LINE;
                    res_next.out_x       = round_pt(acc_x_reg.f);
                    res_next.out_y       = round_pt(acc_y_reg.f);
                    res_next.last_of_run = last_pt;
                    acc_x_next           = step_axis(acc_x_reg);
                    acc_y_next           = step_axis(acc_y_reg);
                    cnt_next             = cnt_reg + CNT_W'(1);
                    if (last_pt)
                    begin
                        pop        = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_x_reg <= acc_x_next;
        acc_y_reg <= acc_y_next;
        res_reg   <= res_next;
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && can_load && last_pt) |=> (res_valid && res_data.last_of_run))
        else $error("final curve point not marked");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (cnt_reg <= CNT_W'(SEGMENTS)))
        else $error("sample counter past end of curve");

endmodule

// ===== hw/rtl/bezier_path_flattener_unit.sv =====
// ----------------------------------------------------------------------------
// bezier_path_flattener_unit: path segment to polyline converter
// Request channel (req_valid/req_ready/req_data) takes one segment: close,
// move, line, quadratic or cubic Bezier in signed Q16.16. Result channel
// (res_valid/res_ready/res_data) gives close, move or line points; the final
// result of each request has last_of_run set. Undefined kinds give nothing.
// Close, move and line give one result; a curve gives SEGMENTS+1 points
// sampled at t = i/SEGMENTS, rounded half up, starting at the pen position.
// A request is written into the queue; a close, move or line goes from the
// queue head into the output register, while a curve first passes ST_LOAD,
// then ST_RUN writes one point per cycle to the output register while the
// receiver accepts results, stepping the back end's difference loop.
// A two-entry queue lets requests be taken while a curve is being walked.
// Reset clears the pen position to the origin and empties the queue.
// When the receiver stalls the current result holds in the output register,
// the evaluator waits and requests back up once the queue is full.
// ----------------------------------------------------------------------------
module bezier_path_flattener_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  bpf_pkg::seg_req_t  req_data,
    output logic               res_valid,
    input  logic               res_ready,
    output bpf_pkg::pt_res_t   res_data
);
    import bpf_pkg::*;

    logic      q_full;
    logic      q_push;
    q_entry_t  q_push_data;
    logic      q_pop;
    logic      q_head_valid;
    q_entry_t  q_head;

    bpf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_push_data)
    );

    bpf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    bpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

endmodule
